@@ rtl/ssort_pkg.sv @@
`default_nettype none

package ssort_pkg;

    // Default number of elements one set can hold.
    localparam int DEPTH_DEFAULT = 64;

    // Entries in the queue between the front and the back; a power of two.
    localparam int QUEUE_DEPTH = 4;

    // Width of one element.
    localparam int VALUE_W = 32;

    // One accepted beat as it travels through the queue.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } item_t;

    // Sequencer states of the back part.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEL_START,
        ST_SEL_SCAN,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_EMIT_RD,
        ST_EMIT_LD
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/ssort_ram.sv @@
`default_nettype none

module ssort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; read data holds when idle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ssort_front.sv @@
`default_nettype none

module ssort_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic [ssort_pkg::VALUE_W-1:0] value,
    input  wire logic                          last,
    output logic                               q_valid,
    output ssort_pkg::item_t                   q_item,
    input  wire logic                          q_pop
);

    import ssort_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    item_t          q_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] fill_reg;
    logic [QCW-1:0] fill_next;
    logic           push;
    logic           pop;

    // A beat is taken whenever the queue has room.
    assign item_ready = (fill_reg != QCW'(QUEUE_DEPTH));
    assign push       = item_valid && item_ready;
    assign q_valid    = (fill_reg != '0);
    assign pop        = q_pop && q_valid;
    assign q_item     = q_reg[rd_ptr_reg];

    // Fill count follows pushes and pops.
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QCW'(1);
        end
    end

    // Queue pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{value: value, last: last};
        end
    end

endmodule

`default_nettype wire

@@ rtl/ssort_back.sv @@
`default_nettype none

module ssort_back #(
    parameter int DEPTH = ssort_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire ssort_pkg::item_t              q_item,
    output logic                               q_pop,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [ssort_pkg::VALUE_W-1:0]      sorted_value,
    output logic                               end_of_set,
    output logic                               overflowed
);

    import ssort_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    back_state_t        state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic [AW-1:0]      issue_idx_reg, issue_idx_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic [VALUE_W-1:0] best_val_reg, best_val_next;
    logic [VALUE_W-1:0] pos_val_reg, pos_val_next;
    logic [AW-1:0]      emit_idx_reg, emit_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_end_reg, out_end_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               ram_we;
    logic [AW-1:0]      ram_wr_addr;
    logic [VALUE_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;
    logic [CW-1:0]      count_inc;
    logic               last_emit;

    ssort_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign result_valid = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign end_of_set   = out_end_reg;
    assign overflowed   = out_ovf_reg;

    assign last_emit = ((CW'(emit_idx_reg) + CW'(1)) == count_reg);

    // Sequencer: load, select the minimum of the tail, swap, then emit.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        issue_idx_next = issue_idx_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        pos_val_next   = pos_val_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_end_next   = out_end_reg;
        out_ovf_next   = out_ovf_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_wr_addr    = '0;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;
        count_inc      = count_reg;

        // The output register empties when its beat is taken.
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    // Store the element, or drop it and note the overflow.
                    if (count_reg != CW'(DEPTH))
                    begin
                        ram_we      = 1'b1;
                        ram_wr_addr = count_reg[AW-1:0];
                        ram_wr_data = q_item.value;
                        count_inc   = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    count_next = count_inc;
                    if (q_item.last)
                    begin
                        pos_next      = '0;
                        emit_idx_next = '0;
                        if (count_inc == CW'(1))
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = ST_SEL_START;
                        end
                    end
                end
            end

            ST_SEL_START:
            begin
                ram_rd_en      = 1'b1;
                ram_rd_addr    = pos_reg;
                issue_idx_next = pos_reg;
                scan_next      = CW'(pos_reg) + CW'(1);
                state_next     = ST_SEL_SCAN;
            end

            ST_SEL_SCAN:
            begin
                // Compare the word read last cycle; the first strictly smaller wins.
                if (issue_idx_reg == pos_reg)
                begin
                    best_val_next = ram_rd_data;
                    pos_val_next  = ram_rd_data;
                    best_idx_next = pos_reg;
                end
                else if ($signed(ram_rd_data) < $signed(best_val_reg))
                begin
                    best_val_next = ram_rd_data;
                    best_idx_next = issue_idx_reg;
                end
                if (scan_reg < count_reg)
                begin
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = scan_reg[AW-1:0];
                    issue_idx_next = scan_reg[AW-1:0];
                    scan_next      = scan_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_SWAP_A;
                end
            end

            ST_SWAP_A:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = best_idx_reg;
                ram_wr_data = pos_val_reg;
                state_next  = ST_SWAP_B;
            end

            ST_SWAP_B:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = pos_reg;
                ram_wr_data = best_val_reg;
                pos_next    = pos_reg + AW'(1);
                if ((CW'(pos_reg) + CW'(2)) < count_reg)
                begin
                    state_next = ST_SEL_START;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end

            ST_EMIT_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = emit_idx_reg;
                state_next  = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                // Read data holds until the output register has room.
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = ram_rd_data;
                    out_end_next   = last_emit;
                    out_ovf_next   = ovf_reg;
                    if (last_emit)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + AW'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        scan_reg      <= scan_next;
        issue_idx_reg <= issue_idx_next;
        best_idx_reg  <= best_idx_next;
        best_val_reg  <= best_val_next;
        pos_val_reg   <= pos_val_next;
        emit_idx_reg  <= emit_idx_next;
        out_value_reg <= out_value_next;
        out_end_reg   <= out_end_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

`default_nettype wire

@@ rtl/selection_sorter.sv @@
`default_nettype none

// Selection sorter. Signed 32-bit values arrive one per beat on the item
// channel; the beat with last high closes the set. Up to DEPTH values are
// kept, further ones are dropped and every result of that set then carries
// overflowed. The set comes out on the result channel in ascending order,
// one value per beat, with end_of_set on the final one. A four-entry queue
// in front of the sorter keeps taking beats while a set is being sorted or
// emitted. Sorting a set of n values runs one scan per position over a
// store with one write port and one registered read port, and each value
// is read from the store again before it goes out. The store needs no
// clearing after reset.
module selection_sorter #(
    parameter int DEPTH = ssort_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_valid,
    output logic                                      item_ready,
    input  wire logic signed [ssort_pkg::VALUE_W-1:0] value,
    input  wire logic                                 last,
    output logic                                      result_valid,
    input  wire logic                                 result_ready,
    output logic signed [ssort_pkg::VALUE_W-1:0]      sorted_value,
    output logic                                      end_of_set,
    output logic                                      overflowed
);

    import ssort_pkg::*;

    logic               q_valid;
    item_t              q_item;
    logic               q_pop;
    logic [VALUE_W-1:0] sorted_bits;

    ssort_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .value      (value),
        .last       (last),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    ssort_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sorted_value (sorted_bits),
        .end_of_set   (end_of_set),
        .overflowed   (overflowed)
    );

    assign sorted_value = $signed(sorted_bits);

endmodule

`default_nettype wire

@@ verif/sort_checker.sv @@
module sort_checker #(
    parameter int DEPTH = ssort_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    input  logic                                 item_ready,
    input  logic signed [ssort_pkg::VALUE_W-1:0] value,
    input  logic                                 last,
    input  logic                                 result_valid,
    input  logic                                 result_ready,
    input  logic signed [ssort_pkg::VALUE_W-1:0] sorted_value,
    input  logic                                 end_of_set,
    input  logic                                 overflowed,
    output int                                   mismatches,
    output int                                   awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import ssort_pkg::*;

    // One beat of the sorted output as it should appear.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      eos;
        logic                      ovf;
    } sorted_beat_t;

    // Shadow copy of the set being collected.
    logic signed [VALUE_W-1:0] held [DEPTH];
    int                        held_count = 0;
    logic                      dropped = 1'b0;

    // Sorted beats still owed by the block, oldest first.
    sorted_beat_t due_beats[$];
    sorted_beat_t want;

    // Sort the collected set in ascending order, first minimum on ties, and queue it.
    function automatic void close_set();
        int                        n;
        int                        pos;
        int                        scan;
        int                        best;
        logic signed [VALUE_W-1:0] swap;
        n = held_count;
        for (pos = 0; pos + 1 < n; pos++)
        begin
            best = pos;
            for (scan = pos + 1; scan < n; scan++)
            begin
                if (held[scan] < held[best])
                    best = scan;
            end
            swap       = held[best];
            held[best] = held[pos];
            held[pos]  = swap;
        end
        for (pos = 0; pos < n; pos++)
            due_beats.push_back('{value: held[pos], eos: (pos == n - 1), ovf: dropped});
        held_count = 0;
        dropped    = 1'b0;
    endfunction

    // Watch both channels at the rising edge; input beats are handled before results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            dropped    = 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                if (held_count < DEPTH)
                begin
                    held[held_count] = value;
                    held_count++;
                end
                else
                    dropped = 1'b1;
                if (last)
                    close_set();
            end
            if (result_valid && result_ready)
            begin
                if (due_beats.size() == 0)
                begin
                    $error("result beat with nothing owed: sorted_value %0d", sorted_value);
                    mismatches++;
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (sorted_value !== want.value)
                    begin
                        $error("sorted_value: expected %0d, got %0d", want.value, sorted_value);
                        mismatches++;
                    end
                    if (end_of_set !== want.eos)
                    begin
                        $error("end_of_set: expected %0b, got %0b", want.eos, end_of_set);
                        mismatches++;
                    end
                    if (overflowed !== want.ovf)
                    begin
                        $error("overflowed: expected %0b, got %0b", want.ovf, overflowed);
                        mismatches++;
                    end
                end
            end
        end
        awaiting = due_beats.size();
    end

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssort_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 200;
    localparam int STALL_CYCLES = 500;
    localparam int TAIL_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 400000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_ready;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      result_valid;
    logic                      result_ready;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      end_of_set;
    logic                      overflowed;

    int mismatches;
    int awaiting;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_requests = 0;
    int stalls_served  = 0;

    // Values of the next set to send; the final one carries last.
    logic signed [VALUE_W-1:0] batch[$];

    always #5 clk = ~clk;

    selection_sorter #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .value       (value),
        .last        (last),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .sorted_value(sorted_value),
        .end_of_set  (end_of_set),
        .overflowed  (overflowed)
    );

    sort_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .value       (value),
        .last        (last),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .sorted_value(sorted_value),
        .end_of_set  (end_of_set),
        .overflowed  (overflowed),
        .mismatches  (mismatches),
        .awaiting    (awaiting)
    );

    // Runaway guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_requests > stalls_served)
            begin
                stalls_served++;
                result_ready = 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge clk);
            end
            else
                result_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one beat, with random idle cycles in front; returns at the falling
    // edge after the beat was taken, with valid still high.
    task automatic send_beat(input logic signed [VALUE_W-1:0] v, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        value      = v;
        last       = l;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_batch();
        int k;
        for (k = 0; k < batch.size(); k++)
            send_beat(batch[k], k == batch.size() - 1);
    endtask

    // Stop offering and wait until every owed sorted beat has come out.
    task automatic drain();
        item_valid = 1'b0;
        while (awaiting != 0)
            @(negedge clk);
    endtask

    // Random element; some sets use a narrow range so that ties are common.
    function automatic logic signed [VALUE_W-1:0] pick_value(input int style);
        logic signed [VALUE_W-1:0] v;
        case (style)
            0:       v = $urandom;
            1:       v = $signed($urandom_range(8)) - 4;
            default:
            begin
                case ($urandom_range(3))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = 0;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    initial
    begin
        int sent;
        int set_index;
        int size;
        int style;
        int k;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        value      = '0;
        last       = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 55;

        // Sets of one at both extremes.
        batch = {32'sh7FFF_FFFF};
        send_batch();
        batch = {32'sh8000_0000};
        send_batch();
        // Extremes mixed with repeated values.
        batch = {32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sh1, -32'sd1,
                 32'sh8000_0000, 32'sh5, 32'sh7FFF_FFFF, 32'sh0};
        send_batch();
        // Descending and already ascending input.
        batch = {32'sh3, 32'sh2, 32'sh1, 32'sh0, -32'sd1};
        send_batch();
        batch = {-32'sd2, -32'sd1, 32'sh0, 32'sh1, 32'sh2};
        send_batch();

        // Random sets: mostly small, a few around or beyond the store size.
        sent      = 0;
        set_index = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= 2 * RANDOM_ITEMS / 3 && send_idle_pct != 0)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (sent >= RANDOM_ITEMS / 3 && send_idle_pct == 20)
            begin
                // Let the output run dry once before swapping the idle rates.
                drain();
                send_idle_pct = 55;
                recv_idle_pct = 20;
            end

            if (set_index == 4)
                size = DEPTH;
            else if (set_index == 12)
                size = DEPTH + 6;
            else if ($urandom_range(19) == 0)
                size = $urandom_range(DEPTH + 8, DEPTH - 2);
            else
                size = $urandom_range(12, 1);
            style = $urandom_range(2);

            batch.delete();
            for (k = 0; k < size; k++)
                batch.push_back(pick_value(style));
            send_batch();
            sent += size;
            set_index++;
        end

        // Hold the output off while more sets arrive, so the input backs up.
        drain();
        stall_requests++;
        batch.delete();
        for (k = 0; k < 8; k++)
            batch.push_back(pick_value(0));
        send_batch();
        batch.delete();
        for (k = 0; k < 24; k++)
            batch.push_back(pick_value(1));
        send_batch();

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ssort_pkg.sv
rtl/ssort_ram.sv
rtl/ssort_front.sv
rtl/ssort_back.sv
rtl/selection_sorter.sv
verif/sort_checker.sv
verif/tb.sv
